// ===== hw/rtl/lzw_stream_compressor_top_defines.svh =====
// Assertion macros shared by the LZW stream compressor RTL.
`ifndef LZW_STREAM_COMPRESSOR_TOP_DEFINES_SVH
`define LZW_STREAM_COMPRESSOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lsc assertion failed: same-cycle implication");
`define LSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lsc assertion failed: next-cycle implication");
`else
`define LSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/lsc_pkg.sv =====
// Shared types and constants of the LZW stream compressor.
package lsc_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int SYM_W             = 8;
    localparam int CODE_VALUE_W      = 12;
    localparam int CODE_WIDTH_W      = 4;
    localparam int WREG_W            = 5;
    localparam int ROOTS_7           = 128;
    localparam int ROOTS_8           = 256;
    localparam int ROOT_BITS_7       = 7;
    localparam int ROOT_BITS_8       = 8;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'h0001,
        S_IDLE    = 13'h0002,
        S_DECIDE  = 13'h0004,
        S_ERR     = 13'h0008,
        S_SCAN    = 13'h0010,
        S_UNL_E   = 13'h0020,
        S_UNL_H   = 13'h0040,
        S_UNL_W   = 13'h0080,
        S_WALK_HD = 13'h0100,
        S_WALK_H2 = 13'h0200,
        S_WALK_CK = 13'h0400,
        S_MISS    = 13'h0800,
        S_LAST    = 13'h1000
    } t_state;

    typedef struct packed {
        logic accept;
        logic restart;
        logic clear;
        logic set_first;
        logic adv;
        logic scan_next;
        logic scan_take;
        logic unl_p;
        logic unl_head_wr;
        logic unl_t;
        logic unl_t_next;
        logic unl_sib_wr;
        logic walk_hd;
        logic walk_start;
        logic walk_next;
        logic hit;
        logic miss;
        logic push_err;
        logic push_flush;
    } t_cmd;

    typedef struct packed {
        logic can_push;
        logic bad_sym;
        logic pv;
        logic last;
        logic consumed;
        logic at_max;
        logic clr_done;
        logic scan_hit;
        logic head_is_s;
        logic t_zero;
        logic sym_match;
        logic sib_is_s;
    } t_sts;

endpackage

// ===== hw/rtl/lzw_stream_compressor_top.sv =====
// Top level of the LZW stream compressor: stream ports, controller and datapath.
// Steps: a byte that misses passes IDLE, DECIDE, WALK_HD, WALK_H2, WALK_CK (once per
//   child-list node walked), MISS, which emits its code, and LAST; recycling at full width adds
//   SCAN per slot probed and an unlink via UNL_E, UNL_H and UNL_W (once per sibling visited).
//   A new byte is taken only once the last is through; the child-list walk sets the pace.
// Reset (synchronous, active low), every end of stream and every config write start a
//   clearing pass over all 2^MAX_CODE_BITS child-head memory entries; no request is taken then.
module lzw_stream_compressor_top #(
    parameter int MAX_CODE_BITS = lsc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: seven_bit_mode
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    // output codes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] code_value, [15:12] code_width
    output logic        m_axis_tlast,   // final_code
    output logic [0:0]  m_axis_tuser    // [0] symbol_error
);
    import lsc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    logic [CODE_VALUE_W-1:0] code_value;
    logic [CODE_WIDTH_W-1:0] code_width;
    logic                    final_code;
    logic                    symbol_error;

    // sequencer: accept a byte, advance the slot, walk the child list, emit
    lsc_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // dictionary tables, slot bookkeeping and the output register
    lsc_datapath #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_stream (s_axis_tlast),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_code_value    (code_value),
        .o_code_width    (code_width),
        .o_final_code    (final_code),
        .o_symbol_error  (symbol_error)
    );

    // pack the result fields, lowest field first
    assign m_axis_tdata    = {code_width, code_value};
    assign m_axis_tlast    = final_code;
    assign m_axis_tuser[0] = symbol_error;

endmodule

// ===== hw/rtl/lsc_datapath.sv =====
// Datapath of the LZW stream compressor: dictionary memories, slot state, output register.
module lsc_datapath #(
    parameter int MAX_CODE_BITS = lsc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic [lsc_pkg::SYM_W-1:0]         i_data_byte,
    input  logic                              i_end_of_stream,
    input  lsc_pkg::t_cmd                     i_cmd,
    output lsc_pkg::t_sts                     o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [lsc_pkg::CODE_VALUE_W-1:0]  o_code_value,
    output logic [lsc_pkg::CODE_WIDTH_W-1:0]  o_code_width,
    output logic                              o_final_code,
    output logic                              o_symbol_error
);
    import lsc_pkg::*;

    localparam int W     = MAX_CODE_BITS;
    localparam int LW    = W + 1;
    localparam int DEPTH = 1 << W;

    logic [W-1:0]     r_child_mem  [DEPTH];
    logic [W-1:0]     r_prefix_mem [DEPTH];
    logic [SYM_W-1:0] r_sym_mem    [DEPTH];
    logic [W-1:0]     r_sib_mem    [DEPTH];

    logic [W-1:0]     r_child_rd;
    logic [W-1:0]     r_eprefix_rd;
    logic [SYM_W-1:0] r_esym_rd;
    logic [W-1:0]     r_esib_rd;

    logic              r_mode;
    logic [SYM_W-1:0]  r_ch;
    logic              r_last;
    logic              r_pv;
    logic [W-1:0]      r_prefix;
    logic [W-1:0]      r_cur;
    logic [LW-1:0]     r_up;
    logic [W-1:0]      r_fill;
    logic [WREG_W-1:0] r_wnow;
    logic [WREG_W-1:0] r_wnext;
    logic [LW-1:0]     r_limit;
    logic              r_cons;
    logic [LW-1:0]     r_i;
    logic [LW-1:0]     n_i;
    logic [W-1:0]      r_s;
    logic [W-1:0]      r_p;
    logic [W-1:0]      r_sib;
    logic [W-1:0]      r_t;
    logic [W-1:0]      n_t;
    logic [W-1:0]      r_head;
    logic [W-1:0]      r_clr;

    logic                    r_ovalid;
    logic [CODE_VALUE_W-1:0] r_ocode;
    logic [CODE_WIDTH_W-1:0] r_owidth;
    logic                    r_ofin;
    logic                    r_oerr;

    logic              restart;
    logic              new_mode;
    logic [W-1:0]      new_roots;
    logic [WREG_W-1:0] new_w;
    logic [W-1:0]      roots_now;
    logic [LW-1:0]     scan_base;
    logic [LW-1:0]     scan_inc;
    logic [LW-1:0]     scan_wrap;
    logic [LW-1:0]     up_inc;
    logic [W-1:0]      caddr;
    logic [W-1:0]      eaddr;
    logic              c_we;
    logic [W-1:0]      c_waddr;
    logic [W-1:0]      c_wdata;
    logic              e_we_sib;
    logic [W-1:0]      e_sib_waddr;
    logic [W-1:0]      e_sib_wdata;
    logic              push;
    logic              can_push;
    logic              at_max;

    assign restart   = !i_rst_n || i_cmd.restart;
    assign new_mode  = !i_rst_n ? 1'b0 : (i_cfg_we ? i_cfg_wdata : r_mode);
    assign new_roots = new_mode ? W'(ROOTS_7) : W'(ROOTS_8);
    assign new_w     = new_mode ? WREG_W'(ROOT_BITS_7 + 1) : WREG_W'(ROOT_BITS_8 + 1);
    assign roots_now = r_mode ? W'(ROOTS_7) : W'(ROOTS_8);
    assign at_max    = (r_wnext >= WREG_W'(W));
    assign up_inc    = r_up + LW'(1);

    // circular scan index: step, wrap to the first non-root slot, mask
    assign scan_base = i_cmd.adv ? r_up : r_i;
    assign scan_inc  = scan_base + LW'(1);
    assign scan_wrap = (scan_inc >= r_limit) ? {1'b0, roots_now} : {1'b0, scan_inc[W-1:0]};

    always_comb begin
        n_i = r_i;
        if (i_cmd.scan_next) begin
            n_i = scan_wrap;
        end
    end

    always_comb begin
        n_t = r_t;
        if (i_cmd.walk_start || i_cmd.unl_t) begin
            n_t = r_child_rd;
        end else if (i_cmd.walk_next || i_cmd.unl_t_next) begin
            n_t = r_esib_rd;
        end
    end

    always_comb begin
        caddr = r_i[W-1:0];
        if (i_cmd.scan_next) begin
            caddr = scan_wrap[W-1:0];
        end else if (i_cmd.unl_p) begin
            caddr = r_eprefix_rd;
        end else if (i_cmd.walk_hd) begin
            caddr = r_prefix;
        end
    end

    assign eaddr = i_cmd.scan_take ? r_i[W-1:0] : n_t;

    assign c_we    = i_cmd.clear || i_cmd.unl_head_wr || i_cmd.miss;
    assign c_waddr = i_cmd.clear ? r_clr : (i_cmd.unl_head_wr ? r_p : r_prefix);
    assign c_wdata = i_cmd.clear ? '0 : (i_cmd.unl_head_wr ? r_sib : r_fill);

    assign e_we_sib    = i_cmd.miss || i_cmd.unl_sib_wr;
    assign e_sib_waddr = i_cmd.miss ? r_fill : r_t;
    assign e_sib_wdata = i_cmd.miss ? r_head : r_sib;

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_child_mem[c_waddr] <= c_wdata;
        end
        r_child_rd <= r_child_mem[caddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.miss) begin
            r_prefix_mem[r_fill] <= r_prefix;
            r_sym_mem[r_fill]    <= r_ch;
        end
        if (e_we_sib) begin
            r_sib_mem[e_sib_waddr] <= e_sib_wdata;
        end
        r_eprefix_rd <= r_prefix_mem[eaddr];
        r_esym_rd    <= r_sym_mem[eaddr];
        r_esib_rd    <= r_sib_mem[eaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_mode <= new_mode;
        end
        if (i_cmd.accept) begin
            r_ch   <= i_data_byte;
            r_last <= i_end_of_stream;
        end
        if (i_cmd.unl_p) begin
            r_p   <= r_eprefix_rd;
            r_sib <= r_esib_rd;
        end
        if (i_cmd.walk_start) begin
            r_head <= r_child_rd;
        end
        if (i_cmd.scan_take) begin
            r_s <= r_i[W-1:0];
        end
        r_i <= n_i;
        r_t <= n_t;

        if (restart) begin
            r_pv     <= 1'b0;
            r_prefix <= '0;
            r_wnext  <= new_w;
            r_wnow   <= new_w;
            r_limit  <= LW'(1) << new_w;
            r_cur    <= new_roots;
            r_up     <= {1'b0, new_roots} + LW'(1);
            r_fill   <= '0;
            r_cons   <= 1'b1;
            r_clr    <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + W'(1);
            end
            if (i_cmd.set_first) begin
                r_prefix <= W'(r_ch);
                r_pv     <= 1'b1;
            end
            if (i_cmd.adv) begin
                r_cons <= 1'b0;
                r_fill <= r_cur;
                r_wnow <= r_wnext;
                if (!at_max) begin
                    r_cur <= r_up[W-1:0];
                    r_up  <= up_inc;
                    if (up_inc == r_limit) begin
                        r_wnext <= r_wnext + WREG_W'(1);
                        r_limit <= r_limit << 1;
                    end
                end
            end
            if (i_cmd.scan_take) begin
                r_cur <= r_i[W-1:0];
                r_up  <= r_i;
            end
            if (i_cmd.hit) begin
                r_prefix <= r_t;
            end
            if (i_cmd.miss) begin
                r_cons   <= 1'b1;
                r_prefix <= W'(r_ch);
            end
        end
    end

    // output register: load when empty or being drained
    assign can_push = !r_ovalid || i_out_ready;
    assign push     = i_cmd.miss || i_cmd.push_err || i_cmd.push_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (push) begin
            r_ocode  <= i_cmd.push_err ? '0 : CODE_VALUE_W'(r_prefix);
            r_owidth <= i_cmd.push_err ? '0 :
                        (i_cmd.miss ? r_wnow[CODE_WIDTH_W-1:0] : r_wnext[CODE_WIDTH_W-1:0]);
            r_ofin   <= i_cmd.push_flush;
            r_oerr   <= i_cmd.push_err;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_code_value   = r_ocode;
    assign o_code_width   = r_owidth;
    assign o_final_code   = r_ofin;
    assign o_symbol_error = r_oerr;

    always_comb begin
        o_sts           = '0;
        o_sts.can_push  = can_push;
        o_sts.bad_sym   = r_mode && r_ch[SYM_W-1];
        o_sts.pv        = r_pv;
        o_sts.last      = r_last;
        o_sts.consumed  = r_cons;
        o_sts.at_max    = at_max;
        o_sts.clr_done  = &r_clr;
        o_sts.scan_hit  = (r_child_rd == '0);
        o_sts.head_is_s = (r_child_rd == r_s);
        o_sts.t_zero    = (r_t == '0);
        o_sts.sym_match = (r_esym_rd == r_ch);
        o_sts.sib_is_s  = (r_esib_rd == r_s);
    end

endmodule

// ===== hw/rtl/lsc_controller.sv =====
// Sequencing state machine of the LZW stream compressor.
`include "lzw_stream_compressor_top_defines.svh"
module lsc_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  lsc_pkg::t_sts i_sts,
    output lsc_pkg::t_cmd o_cmd
);
    import lsc_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        cmd       = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.bad_sym) begin
                    n_state = S_ERR;
                end else if (!i_sts.pv) begin
                    cmd.set_first = 1'b1;
                    n_state       = S_LAST;
                end else if (i_sts.consumed) begin
                    cmd.adv = 1'b1;
                    if (i_sts.at_max) begin
                        cmd.scan_next = 1'b1;
                        n_state       = S_SCAN;
                    end else begin
                        n_state = S_WALK_HD;
                    end
                end else begin
                    n_state = S_WALK_HD;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    cmd.scan_take = 1'b1;
                    n_state       = S_UNL_E;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_UNL_E: begin
                cmd.unl_p = 1'b1;
                n_state   = S_UNL_H;
            end
            S_UNL_H: begin
                if (i_sts.head_is_s) begin
                    cmd.unl_head_wr = 1'b1;
                    n_state         = S_WALK_HD;
                end else begin
                    cmd.unl_t = 1'b1;
                    n_state   = S_UNL_W;
                end
            end
            S_UNL_W: begin
                if (i_sts.t_zero) begin
                    n_state = S_WALK_HD;
                end else if (i_sts.sib_is_s) begin
                    cmd.unl_sib_wr = 1'b1;
                    n_state        = S_WALK_HD;
                end else begin
                    cmd.unl_t_next = 1'b1;
                end
            end
            S_WALK_HD: begin
                cmd.walk_hd = 1'b1;
                n_state     = S_WALK_H2;
            end
            S_WALK_H2: begin
                cmd.walk_start = 1'b1;
                n_state        = S_WALK_CK;
            end
            S_WALK_CK: begin
                if (i_sts.t_zero) begin
                    n_state = S_MISS;
                end else if (i_sts.sym_match) begin
                    cmd.hit = 1'b1;
                    n_state = S_LAST;
                end else begin
                    cmd.walk_next = 1'b1;
                end
            end
            S_MISS: begin
                if (i_sts.can_push) begin
                    cmd.miss = 1'b1;
                    n_state  = S_LAST;
                end
            end
            S_ERR: begin
                if (i_sts.can_push) begin
                    cmd.push_err = 1'b1;
                    n_state      = S_LAST;
                end
            end
            S_LAST: begin
                // end of stream: flush the held prefix, then restart the dictionary
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (!i_sts.pv) begin
                    cmd.restart = 1'b1;
                    n_state     = S_CLEAR;
                end else if (i_sts.can_push) begin
                    cmd.push_flush = 1'b1;
                    cmd.restart    = 1'b1;
                    n_state        = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_cfg_we) begin
            cmd         = '0;
            cmd.restart = 1'b1;
            n_state     = S_CLEAR;
        end
    end

    assign o_cmd = cmd;

    `LSC_ASSERT_NEXT(a_accept_decides, i_clk, i_rst_n, i_s_valid && o_s_ready && !i_cfg_we, r_state == S_DECIDE)
    `LSC_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n, cmd.miss || cmd.push_err || cmd.push_flush, i_sts.can_push)
    `LSC_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, cmd.restart, r_state == S_CLEAR)

endmodule

// ===== tb/sv/lzw_code_checker.sv =====
// Checker for the LZW compressor: predicts emitted codes and compares them on the output channel.
`timescale 1ns / 1ps
module lzw_code_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    input  logic        i_out_last,
    input  logic [0:0]  i_out_user,
    output int          o_fail_count,
    output int          o_pending
);
    import lsc_pkg::*;

    localparam int TBL = 1 << MAX_CODE_BITS_DEF;
    localparam logic [11:0] MSK = 12'(TBL - 1);

    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  width;
        logic        fin;
        logic        err;
    } t_code;

    t_code code_queue[$];

    logic        mode7;
    logic [11:0] pfx;
    logic        pfx_ok;
    logic [11:0] e_pfx [TBL];
    logic [7:0]  e_sym [TBL];
    logic [11:0] e_sib [TBL];
    logic [11:0] head  [TBL];
    logic [12:0] cur_slot, nxt_slot, fill, limit;
    logic [3:0]  w_now, w_next;
    logic        used;

    function automatic logic [12:0] roots();
        return mode7 ? 13'(ROOTS_7) : 13'(ROOTS_8);
    endfunction

    task automatic dict_clear();
        for (int i = 0; i < TBL; i++) begin
            e_pfx[i] = '0; e_sym[i] = '0; e_sib[i] = '0; head[i] = '0;
        end
        pfx = '0;
        pfx_ok = 0;
        w_next = mode7 ? 4'(ROOT_BITS_7 + 1) : 4'(ROOT_BITS_8 + 1);
        w_now = w_next;
        limit = 13'(1) << w_next;
        cur_slot = roots();
        nxt_slot = cur_slot + 1;
        fill = '0;
        used = 1;
    endtask

    task automatic unlink(input logic [11:0] s);
        logic [11:0] p, t;
        p = e_pfx[s];
        if (head[p] == s) begin
            head[p] = e_sib[s];
            return;
        end
        t = head[p];
        for (int n = 0; t != 0 && n < TBL; n++) begin
            if (e_sib[t] == s) begin
                e_sib[t] = e_sib[s];
                return;
            end
            t = e_sib[t];
        end
    endtask

    task automatic reserve_slot();
        logic [12:0] i;
        if (!used) return;
        used = 0;
        fill = cur_slot & 13'(MSK);
        w_now = w_next;
        if (w_next < MAX_CODE_BITS_DEF) begin
            cur_slot = nxt_slot & 13'(MSK);
            nxt_slot = nxt_slot + 1;
            if (nxt_slot == limit) begin
                w_next++;
                limit = 13'(1) << w_next;
            end
        end else begin
            i = nxt_slot;
            for (int n = 0; n <= TBL; n++) begin
                i++;
                if (i >= limit) i = roots();
                i &= 13'(MSK);
                if (head[i[11:0]] == 0) break;
            end
            cur_slot = i;
            unlink(i[11:0]);
            nxt_slot = i;
        end
    endtask

    // Predict the codes one accepted byte causes.
    task automatic compress_byte(input logic [7:0] ch, input logic last);
        logic [11:0] t;
        logic        hit;
        t_code       c;
        if (mode7 && ch >= 8'd128) begin
            c = '{code: '0, width: '0, fin: 0, err: 1};
            code_queue.push_back(c);
        end else if (!pfx_ok) begin
            pfx = 12'(ch);
            pfx_ok = 1;
        end else begin
            hit = 0;
            reserve_slot();
            t = head[pfx];
            for (int n = 0; t != 0 && n < TBL; n++) begin
                if (e_sym[t] == ch) begin
                    pfx = t;
                    hit = 1;
                    break;
                end
                t = e_sib[t];
            end
            if (!hit) begin
                c = '{code: pfx, width: w_now, fin: 0, err: 0};
                code_queue.push_back(c);
                e_pfx[fill] = pfx;
                e_sym[fill] = ch;
                e_sib[fill] = head[pfx];
                head[pfx] = fill[11:0];
                used = 1;
                pfx = 12'(ch);
            end
        end
        if (last) begin
            if (pfx_ok) begin
                c = '{code: pfx, width: w_next, fin: 1, err: 0};
                code_queue.push_back(c);
            end
            dict_clear();
        end
    endtask

    t_code got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode7 = 0;
            dict_clear();
            code_queue.delete();
            o_fail_count <= 0;
        end else begin
            // Compare the output first: a same-edge input cannot affect it.
            if (i_out_valid && i_out_ready) begin
                got = '{code: i_out_data[11:0], width: i_out_data[15:12],
                        fin: i_out_last, err: i_out_user[0]};
                if (code_queue.size() == 0) begin
                    $display("%0t: unexpected code, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = code_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected code=%h width=%0d fin=%b err=%b",
                                 $time, want.code, want.width, want.fin, want.err);
                        $display("%0t:          actual   code=%h width=%0d fin=%b err=%b",
                                 $time, got.code, got.width, got.fin, got.err);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                mode7 = i_cfg_wdata;
                dict_clear();
            end
            if (i_in_valid && i_in_ready) compress_byte(i_in_byte, i_in_last);
        end
        o_pending <= code_queue.size();
    end

endmodule

// ===== tb/sv/tb_lzw_stream_compressor_top.sv =====
// Testbench top for the LZW stream compressor: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module tb_lzw_stream_compressor_top;
    import lsc_pkg::*;

    // Clearing pass after reset/flush/config write walks the whole child-head memory; allow lots of slack.
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_WAIT = 200;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    int fail_count, pending;
    int quiet_cycles = 0;
    bit hold_off = 0;         // long receiver stall requested by the stimulus
    bit gaps_on = 1;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    lzw_stream_compressor_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    lzw_code_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_byte(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .i_out_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall on its own pattern, with calm stretches and the long hold-off.
    always @(posedge i_clk) begin
        int mood;
        mood = $urandom_range(0, 99);
        if (hold_off) m_axis_tready <= 0;
        else if (!gaps_on) m_axis_tready <= 1;
        else m_axis_tready <= (mood < 65);
    end

    // Watchdog: count cycles in which neither channel moves.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    int burst_left = 0;
    int sent = 0;

    // Offer one request and hold it until accepted; gaps fall between bursts.
    // Valid stays high after acceptance so back-to-back requests need no second drive.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Wait out every expected code, then the block's tail before a register write.
    task automatic drain();
        s_axis_tvalid <= 0;
        do @(posedge i_clk); while (pending != 0 || s_axis_tvalid);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        i_cfg_we    <= 1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 0;
    endtask

    // Random stream: mostly text from a small alphabet so the dictionary grows deep.
    task automatic send_stream(input int len, input logic m7, input int alpha);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 90) b = 8'($urandom_range(0, alpha - 1)) + 8'h61;
            else b = m7 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: single byte, extremes, a repeat run, and the end marker on a byte.
        send_byte(8'h00, 1);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        write_mode(1);
        // 7-bit mode: bad symbols alone, mid-stream and on the last byte.
        send_byte(8'h80, 1);
        send_byte(8'h7F, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h7F, 0);
        send_byte(8'h7F, 0);
        send_byte(8'h00, 0);
        send_byte(8'hAA, 1);
        send_byte(8'h55, 0);
        send_byte(8'h55, 1);

        // Long hold-off: the sender keeps offering while the receiver stalls.
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            send_stream(60, 1, 2);
        join

        // Random part: streams in both modes; long ones widen the codes.
        for (int ph = 0; ph < 4; ph++) begin
            write_mode(ph[0]);
            gaps_on = (ph != 2);
            send_stream(ph == 3 ? 700 : 150, ph[0], 2 + ph);
            send_stream($urandom_range(1, 20), ph[0], 26);
        end
        // Constant byte run: one long chain that grows ever longer prefixes.
        write_mode(1);
        gaps_on = 0;
        send_stream(1, 1, 1);
        for (int i = 0; i < 300; i++) send_byte(8'h61, i == 299);
        gaps_on = 1;
        write_mode(0);
        while (sent < 1850) begin
            send_stream($urandom_range(2, 40), 0, 256 - 'h61);
        end

        drain();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_datapath.sv
hw/rtl/lsc_controller.sv
hw/rtl/lzw_stream_compressor_top.sv
tb/sv/lzw_code_checker.sv
tb/sv/tb_lzw_stream_compressor_top.sv
